// ----- hw/rtl/stack_machine_executor_macros.svh -----
// Assertion macros used by the stack machine executor checker
`ifndef STACK_MACHINE_EXECUTOR_MACROS_SVH
`define STACK_MACHINE_EXECUTOR_MACROS_SVH

// same-cycle implication, sampled on clk, held off during reset
`define SME_ASSERT_IMP(lbl, cond, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error("sme check failed");

// next-cycle implication, sampled on clk, held off during reset
`define SME_ASSERT_NXT(lbl, cond, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error("sme check failed");

`endif

// ----- hw/rtl/sme_pkg.sv -----
// Types, codes and constants of the stack machine executor
`timescale 1ns / 1ps

package sme_pkg;

	localparam int unsigned DATA_W = 32;
	localparam int unsigned DEPTH_W = 11;
	localparam int unsigned KIND_W = 3;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned CNT_W = $clog2(DATA_W);
	localparam int unsigned STACK_DEPTH_DEF = 1024;

	localparam logic [KIND_W-1:0] KIND_PUSH  = 3'd0;
	localparam logic [KIND_W-1:0] KIND_POP   = 3'd1;
	localparam logic [KIND_W-1:0] KIND_ADD   = 3'd2;
	localparam logic [KIND_W-1:0] KIND_SUB   = 3'd3;
	localparam logic [KIND_W-1:0] KIND_MUL   = 3'd4;
	localparam logic [KIND_W-1:0] KIND_DIV   = 3'd5;
	localparam logic [KIND_W-1:0] KIND_PRINT = 3'd6;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_OVER  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_UNDER = 2'd2;
	localparam logic [STATUS_W-1:0] ST_DIVZ  = 2'd3;

	typedef struct packed {
		logic [KIND_W-1:0]        kind;
		logic signed [DATA_W-1:0] immediate;
	} sme_in_t;

	typedef struct packed {
		logic [STATUS_W-1:0]      status;
		logic                     printed;
		logic signed [DATA_W-1:0] print_value;
		logic [DEPTH_W-1:0]       depth;
	} sme_out_t;

	typedef struct packed {
		logic              start;
		logic [DATA_W-1:0] dividend;
		logic [DATA_W-1:0] divisor;
	} sme_div_req_t;

	typedef struct packed {
		logic              done;
		logic [DATA_W-1:0] quotient;
	} sme_div_rsp_t;

endpackage

// ----- hw/rtl/sme_div.sv -----
// Iterative signed divider, one quotient bit per cycle, truncating toward zero
`timescale 1ns / 1ps

module sme_div (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sme_pkg::sme_div_req_t req,
	output sme_pkg::sme_div_rsp_t rsp
);

	logic                          busy_q;
	logic                          done_q;
	logic [sme_pkg::CNT_W-1:0]     cnt_q;
	logic [sme_pkg::DATA_W-1:0]    rem_q;
	logic [sme_pkg::DATA_W-1:0]    quo_q;
	logic [sme_pkg::DATA_W-1:0]    dmag_q;
	logic                          neg_q;
	logic [sme_pkg::DATA_W-1:0]    nmag;
	logic [sme_pkg::DATA_W-1:0]    dmag;
	logic [sme_pkg::DATA_W:0]      rem_sh;
	logic [sme_pkg::DATA_W:0]      trial;

	assign nmag = req.dividend[sme_pkg::DATA_W-1] ? (~req.dividend + 1'b1) : req.dividend;
	assign dmag = req.divisor[sme_pkg::DATA_W-1] ? (~req.divisor + 1'b1) : req.divisor;
	assign rem_sh = {rem_q, quo_q[sme_pkg::DATA_W-1]};
	assign trial = rem_sh - {1'b0, dmag_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= busy_q && !req.start && (cnt_q == sme_pkg::CNT_W'(sme_pkg::DATA_W - 1));
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == sme_pkg::CNT_W'(sme_pkg::DATA_W - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= nmag;
			dmag_q <= dmag;
			neg_q <= req.dividend[sme_pkg::DATA_W-1] ^ req.divisor[sme_pkg::DATA_W-1];
		end else if (busy_q) begin
			if (!trial[sme_pkg::DATA_W]) begin
				rem_q <= trial[sme_pkg::DATA_W-1:0];
				quo_q <= {quo_q[sme_pkg::DATA_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[sme_pkg::DATA_W-1:0];
				quo_q <= {quo_q[sme_pkg::DATA_W-2:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quotient = neg_q ? (~quo_q + 1'b1) : quo_q;

endmodule

// ----- hw/rtl/stack_machine_executor.sv -----
// Stack machine executor: one instruction per input beat, one result beat each
// Push, pop, unused codes, overflow and underflow go from IDLE to OUT; print passes RDA;
// divide by zero passes RDA, RDB; add, sub, mul pass RDA, RDB, WR; div RDA, RDB, DIV, WR.
// DIV waits on the one-bit-per-cycle divider; the stack memory has one read port, so binary
// operations read twice. One instruction at a time; the next waits until the result loads.
// Reset clears the stack pointer, the sequencer and the output beat; stack memory keeps no reset.
`timescale 1ns / 1ps

module stack_machine_executor #(
	parameter int unsigned STACK_DEPTH = sme_pkg::STACK_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  sme_pkg::sme_in_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output sme_pkg::sme_out_t out_data
);

	localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int unsigned PW = $clog2(STACK_DEPTH + 1);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_RDA  = 6'b000010,
		S_RDB  = 6'b000100,
		S_DIV  = 6'b001000,
		S_WR   = 6'b010000,
		S_OUT  = 6'b100000
	} state_t;

	state_t                              state_q, state_d;
	logic [PW-1:0]                       sp_q, sp_d, sp_m1, sp_m2;
	logic                                out_valid_q;
	sme_pkg::sme_out_t                   out_q;
	logic [sme_pkg::KIND_W-1:0]          kind_q;
	logic [sme_pkg::DATA_W-1:0]          second_q;
	logic [sme_pkg::DATA_W-1:0]          res_q;
	logic [sme_pkg::STATUS_W-1:0]        rst_status_q;
	logic                                rst_printed_q;
	logic [sme_pkg::DATA_W-1:0]          rst_pval_q;
	logic [sme_pkg::DATA_W-1:0]          mem [STACK_DEPTH];
	logic [sme_pkg::DATA_W-1:0]          rd_q;
	logic [AW-1:0]                       rd_addr, wr_addr;
	logic [sme_pkg::DATA_W-1:0]          wr_data;
	logic                                we;
	logic                                res_ld, alu_ld, out_ld;
	logic [sme_pkg::STATUS_W-1:0]        status_d;
	logic                                printed_d;
	logic [sme_pkg::DATA_W-1:0]          pval_d;
	logic [sme_pkg::DATA_W-1:0]          alu_out;
	logic [sme_pkg::DATA_W-1:0]          prod;
	sme_pkg::sme_div_req_t               div_req;
	sme_pkg::sme_div_rsp_t               div_rsp;

	assign sp_m1 = sp_q - PW'(1);
	assign sp_m2 = sp_q - PW'(2);
	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data = out_q;
	assign out_ld = (state_q == S_OUT) && (!out_valid_q || out_ready);
	assign prod = rd_q * second_q;

	always_comb begin
		unique case (kind_q)
			sme_pkg::KIND_ADD: alu_out = rd_q + second_q;
			sme_pkg::KIND_SUB: alu_out = rd_q - second_q;
			default:           alu_out = prod;
		endcase
	end

	always_comb begin
		state_d = state_q;
		sp_d = sp_q;
		we = 1'b0;
		wr_addr = sp_q[AW-1:0];
		wr_data = in_data.immediate;
		rd_addr = sp_m1[AW-1:0];
		res_ld = 1'b0;
		alu_ld = 1'b0;
		status_d = sme_pkg::ST_OK;
		printed_d = 1'b0;
		pval_d = '0;
		div_req.start = 1'b0;
		div_req.dividend = rd_q;
		div_req.divisor = second_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					res_ld = 1'b1;
					state_d = S_OUT;
					priority if (in_data.kind == sme_pkg::KIND_PUSH) begin
						if (sp_q == PW'(STACK_DEPTH)) begin
							status_d = sme_pkg::ST_OVER;
						end else begin
							we = 1'b1;
							sp_d = sp_q + PW'(1);
						end
					end else if (in_data.kind == sme_pkg::KIND_POP) begin
						if (sp_q == '0) begin
							status_d = sme_pkg::ST_UNDER;
						end else begin
							sp_d = sp_m1;
						end
					end else if (in_data.kind == sme_pkg::KIND_PRINT) begin
						if (sp_q == '0) begin
							status_d = sme_pkg::ST_UNDER;
						end else begin
							state_d = S_RDA;
						end
					end else if (in_data.kind == sme_pkg::KIND_ADD ||
						in_data.kind == sme_pkg::KIND_SUB ||
						in_data.kind == sme_pkg::KIND_MUL ||
						in_data.kind == sme_pkg::KIND_DIV) begin
						if (sp_q < PW'(2)) begin
							status_d = sme_pkg::ST_UNDER;
						end else begin
							state_d = S_RDA;
						end
					end else begin
						state_d = S_OUT;
					end
				end
			end
			S_RDA: begin
				rd_addr = sp_m2[AW-1:0];
				if (kind_q == sme_pkg::KIND_PRINT) begin
					res_ld = 1'b1;
					printed_d = 1'b1;
					pval_d = rd_q;
					sp_d = sp_m1;
					state_d = S_OUT;
				end else begin
					state_d = S_RDB;
				end
			end
			S_RDB: begin
				if (kind_q == sme_pkg::KIND_DIV) begin
					if (second_q == '0) begin
						res_ld = 1'b1;
						status_d = sme_pkg::ST_DIVZ;
						state_d = S_OUT;
					end else begin
						div_req.start = 1'b1;
						state_d = S_DIV;
					end
				end else begin
					alu_ld = 1'b1;
					state_d = S_WR;
				end
			end
			S_DIV: begin
				if (div_rsp.done) begin
					alu_ld = 1'b1;
					state_d = S_WR;
				end
			end
			S_WR: begin
				we = 1'b1;
				wr_addr = sp_m2[AW-1:0];
				wr_data = res_q;
				sp_d = sp_m1;
				res_ld = 1'b1;
				state_d = S_OUT;
			end
			S_OUT: begin
				if (!out_valid_q || out_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sp_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			sp_q <= sp_d;
			if (out_ld) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			kind_q <= in_data.kind;
		end
		if (state_q == S_RDA) begin
			second_q <= rd_q;
		end
		if (alu_ld) begin
			res_q <= (state_q == S_DIV) ? div_rsp.quotient : alu_out;
		end
		if (res_ld) begin
			rst_status_q <= status_d;
			rst_printed_q <= printed_d;
			rst_pval_q <= pval_d;
		end
		if (out_ld) begin
			out_q <= '{
				status:      rst_status_q,
				printed:     rst_printed_q,
				print_value: rst_pval_q,
				depth:       sme_pkg::DEPTH_W'(sp_q)
			};
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	sme_div u_sme_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

endmodule

// ----- hw/rtl/sme_checker.sv -----
// Port checker for the stack machine executor and its bind
`timescale 1ns / 1ps
`include "stack_machine_executor_macros.svh"

module sme_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input sme_pkg::sme_in_t  in_data,
	input logic              out_valid,
	input logic              out_ready,
	input sme_pkg::sme_out_t out_data
);

	`SME_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
	`SME_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
	`SME_ASSERT_IMP(a_printed_ok, out_valid && out_data.printed, out_data.status == sme_pkg::ST_OK)
	`SME_ASSERT_IMP(a_pval_zero, out_valid && !out_data.printed, out_data.print_value == '0)
	`SME_ASSERT_IMP(a_under_shallow, out_valid && out_data.status == sme_pkg::ST_UNDER, out_data.depth < 11'd2)

endmodule

bind stack_machine_executor sme_checker u_sme_checker (.*);
